### hw/rtl/rss_pkg.sv
// Shared types and command codes for the rightmost substring search unit.
package rss_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 7;

  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] byte_value;
    logic              restart;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             overflowed;
  } rsp_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } hit_t;

endpackage

### hw/rtl/rss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rss_search.sv
// Search sequencer: walks start positions from the right, comparing one byte per S_READ/S_CMP pair.
module rss_search #(
  parameter int TEXT_DEPTH    = 128,
  parameter int PATTERN_DEPTH = 128,
  localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1,
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1,
  localparam int LW  = $clog2(TEXT_DEPTH + 1),
  localparam int PLW = $clog2(PATTERN_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [LW-1:0]             text_len,
  input  logic [PLW-1:0]            pat_len,
  output logic [TAW-1:0]            text_raddr,
  output logic [PAW-1:0]            pat_raddr,
  input  logic [rss_pkg::BYTE_W-1:0] text_rdata,
  input  logic [rss_pkg::BYTE_W-1:0] pat_rdata,
  output logic                      busy,
  output logic                      done_valid,
  input  logic                      done_ready,
  output rss_pkg::hit_t             done_hit
);

  localparam int CW  = ((LW > PLW) ? LW : PLW) + 1;
  localparam int SW  = ((LW > PAW) ? LW : PAW) + 1;
  localparam int KW  = ((PAW > PLW) ? PAW : PLW) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state, state_next;
  logic [LW-1:0]       pos, pos_next;
  logic [PAW-1:0]      k, k_next;
  rss_pkg::hit_t       hit, hit_next;

  logic [CW-1:0]       tl_w, pl_w, diff_w;
  logic [SW-1:0]       addr_sum;
  logic [KW-1:0]       k_inc;
  logic [LW+rss_pkg::IDX_W-1:0] pos_wide;
  logic                trivial, last_k;

  assign tl_w     = CW'(text_len);
  assign pl_w     = CW'(pat_len);
  assign diff_w   = tl_w - pl_w;
  assign trivial  = (pat_len == '0) || (pl_w > tl_w);
  assign addr_sum = SW'(pos) + SW'(k);
  assign k_inc    = KW'(k) + KW'(1);
  assign last_k   = (k_inc == KW'(pat_len));
  assign pos_wide = (LW + rss_pkg::IDX_W)'(pos);

  assign text_raddr = addr_sum[TAW-1:0];
  assign pat_raddr  = k;
  assign busy       = (state != S_IDLE);
  assign done_valid = (state == S_DONE);
  assign done_hit   = hit;

  always_comb begin
    state_next = state;
    pos_next   = pos;
    k_next     = k;
    hit_next   = hit;
    case (state)
      S_IDLE: begin
        if (start) begin
          k_next   = '0;
          pos_next = diff_w[LW-1:0];
          hit_next = '0;
          state_next = trivial ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (text_rdata == pat_rdata) begin
          if (last_k) begin
            hit_next.found = 1'b1;
            hit_next.index = pos_wide[rss_pkg::IDX_W-1:0];
            state_next = S_DONE;
          end else begin
            k_next = k_inc[PAW-1:0];
            state_next = S_READ;
          end
        end else if (pos == '0) begin
          state_next = S_DONE;
        end else begin
          pos_next = pos - LW'(1);
          k_next   = '0;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (done_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    pos <= pos_next;
    k   <= k_next;
    hit <= hit_next;
  end

endmodule

### hw/rtl/rightmost_substring_search_unit.sv
// Top level: buffer loading, length tracking, search sequencer and result register.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  rss_pkg::req_t (cmd, byte_value, restart)
//   rsp      out  rsp_valid/rsp_ready  rss_pkg::rsp_t (found, match_index, overflowed)
//
// Store beats are taken back to back while no search is in progress.
// A search holds req_ready low until its result is handed to rsp; each byte
// compare is a read of both RAMs (S_READ) then a compare (S_CMP), and the
// S_DONE state then hands the result to rsp.
// Reset clears lengths, the dropped flag and control; RAM contents are not cleared.
// A finished search waits in the sequencer while rsp holds an untaken beat.
module rightmost_substring_search_unit #(
  parameter int TEXT_DEPTH    = 128,
  parameter int PATTERN_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rss_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rss_pkg::rsp_t rsp
);

  localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int LW  = $clog2(TEXT_DEPTH + 1);
  localparam int PLW = $clog2(PATTERN_DEPTH + 1);

  logic [LW-1:0]  text_len, text_len_next;
  logic [PLW-1:0] pat_len, pat_len_next;
  logic           dropped, dropped_next;

  logic accept, do_text, do_pat, do_search;
  logic text_fits, pat_fits, text_we, pat_we;
  logic [TAW-1:0] text_waddr, text_raddr;
  logic [PAW-1:0] pat_waddr, pat_raddr;
  logic [rss_pkg::BYTE_W-1:0] text_rdata, pat_rdata;

  logic          busy, done_valid, done_ready;
  rss_pkg::hit_t done_hit;

  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;
  assign do_text   = accept && (req.cmd == rss_pkg::CMD_TEXT);
  assign do_pat    = accept && (req.cmd == rss_pkg::CMD_PATTERN);
  assign do_search = accept && (req.cmd == rss_pkg::CMD_SEARCH);

  assign text_fits  = req.restart || (text_len < LW'(TEXT_DEPTH));
  assign pat_fits   = req.restart || (pat_len < PLW'(PATTERN_DEPTH));
  assign text_we    = do_text && text_fits;
  assign pat_we     = do_pat && pat_fits;
  assign text_waddr = req.restart ? '0 : text_len[TAW-1:0];
  assign pat_waddr  = req.restart ? '0 : pat_len[PAW-1:0];

  always_comb begin
    text_len_next = text_len;
    pat_len_next  = pat_len;
    dropped_next  = dropped;
    if (text_we) begin
      text_len_next = req.restart ? LW'(1) : text_len + LW'(1);
    end
    if (pat_we) begin
      pat_len_next = req.restart ? PLW'(1) : pat_len + PLW'(1);
    end
    if ((do_text && !text_fits) || (do_pat && !pat_fits)) begin
      dropped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_len <= '0;
      pat_len  <= '0;
      dropped  <= 1'b0;
    end else begin
      text_len <= text_len_next;
      pat_len  <= pat_len_next;
      dropped  <= dropped_next;
    end
  end

  rss_ram #(
    .WIDTH (rss_pkg::BYTE_W),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (req.byte_value),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  rss_ram #(
    .WIDTH (rss_pkg::BYTE_W),
    .DEPTH (PATTERN_DEPTH)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (req.byte_value),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  rss_search #(
    .TEXT_DEPTH    (TEXT_DEPTH),
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_search (
    .clk        (clk),
    .rst        (rst),
    .start      (do_search),
    .text_len   (text_len),
    .pat_len    (pat_len),
    .text_raddr (text_raddr),
    .pat_raddr  (pat_raddr),
    .text_rdata (text_rdata),
    .pat_rdata  (pat_rdata),
    .busy       (busy),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_hit   (done_hit)
  );

  // result register; a waiting beat only holds back the sequencer
  assign done_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (done_valid && done_ready) begin
      rsp.found       <= done_hit.found;
      rsp.match_index <= done_hit.index;
      rsp.overflowed  <= dropped;
    end
  end

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.match_index == '0)
    else $error("miss reported with nonzero index");

  a_text_len_bound: assert property (@(posedge clk) disable iff (rst)
    (LW + 1)'(text_len) <= (LW + 1)'(TEXT_DEPTH))
    else $error("text length beyond capacity");

  a_dropped_sticky: assert property (@(posedge clk) disable iff (rst)
    dropped |=> dropped)
    else $error("dropped flag cleared without reset");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    do_search |=> !req_ready)
    else $error("request taken during search");

endmodule

### dv/rightmost_substring_search_unit_tb.sv
// Self-checking testbench for the rightmost substring search unit.
`timescale 1ns / 1ps

module rightmost_substring_search_unit_tb;

  localparam int TEXT_DEPTH    = 128;
  localparam int PATTERN_DEPTH = 128;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 50;
  localparam int PRINT_LIMIT   = 40;
  localparam int GROW_LIMIT    = 100;

  localparam logic [rss_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_e;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  rss_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rss_pkg::rsp_t rsp;

  logic [rss_pkg::BYTE_W-1:0] text_mem [TEXT_DEPTH];
  logic [rss_pkg::BYTE_W-1:0] pattern_mem [PATTERN_DEPTH];
  int   text_len    = 0;
  int   pattern_len = 0;
  logic dropped     = 1'b0;
  rss_pkg::rsp_t expected_hits [$];

  int     errors     = 0;
  int     cycles     = 0;
  int     beats_sent = 0;
  int     burst_left = 0;
  int     gap_max    = 4;
  int     stall_left = 0;
  stall_e stall_mode = STALL_NONE;

  rightmost_substring_search_unit #(
    .TEXT_DEPTH   (TEXT_DEPTH),
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rss_pkg::rsp_t predict_search();
    rss_pkg::rsp_t r;
    bit   hit;
    r = '0;
    r.overflowed = dropped;
    if (pattern_len == 0 || pattern_len > text_len) return r;
    for (int s = text_len - pattern_len; s >= 0; s--) begin
      hit = 1'b1;
      for (int k = 0; k < pattern_len; k++) begin
        if (pattern_mem[k] != text_mem[s + k]) hit = 1'b0;
      end
      if (hit) begin
        r.found = 1'b1;
        r.match_index = rss_pkg::IDX_W'(s);
        return r;
      end
    end
    return r;
  endfunction

  function automatic void apply_beat(input rss_pkg::req_t b);
    case (b.cmd)
      rss_pkg::CMD_TEXT: begin
        if (b.restart) text_len = 0;
        if (text_len < TEXT_DEPTH) begin
          text_mem[text_len] = b.byte_value;
          text_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      rss_pkg::CMD_PATTERN: begin
        if (b.restart) pattern_len = 0;
        if (pattern_len < PATTERN_DEPTH) begin
          pattern_mem[pattern_len] = b.byte_value;
          pattern_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      rss_pkg::CMD_SEARCH: expected_hits.push_back(predict_search());
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ready depends on registered state only, so it is settled at the falling edge
  task automatic send_beat(input logic [rss_pkg::CMD_W-1:0] cmd,
                           input logic [rss_pkg::BYTE_W-1:0] value,
                           input logic restart);
    rss_pkg::req_t b;
    b.cmd        = cmd;
    b.byte_value = value;
    b.restart    = restart;
    if (gap_max != 0 && burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    req_valid <= 1'b1;
    req <= b;
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    apply_beat(b);
    if (cmd != CMD_NONE) beats_sent++;
  endtask

  task automatic load_bytes(input logic [rss_pkg::CMD_W-1:0] cmd,
                            input logic [rss_pkg::BYTE_W-1:0] bytes[$]);
    foreach (bytes[i]) send_beat(cmd, bytes[i], i == 0);
  endtask

  task automatic load_string(input logic [rss_pkg::CMD_W-1:0] cmd, input string s);
    for (int i = 0; i < s.len(); i++) send_beat(cmd, s[i], i == 0);
  endtask

  task automatic run_search(input logic restart);
    send_beat(rss_pkg::CMD_SEARCH, rss_pkg::BYTE_W'($urandom), restart);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  // pattern is a slice of the current text two times in three (if text is loaded), else a random mix of bytes a and b
  task automatic send_pattern(input logic [rss_pkg::BYTE_W-1:0] a,
                              input logic [rss_pkg::BYTE_W-1:0] b);
    logic [rss_pkg::BYTE_W-1:0] bytes[$];
    int len;
    int pos;
    if (text_len > 0 && $urandom_range(0, 2) != 0) begin
      len = $urandom_range(1, text_len < 8 ? text_len : 8);
      pos = $urandom_range(0, text_len - len);
      for (int i = 0; i < len; i++) bytes.push_back(text_mem[pos + i]);
    end else begin
      len = $urandom_range(1, 10);
      repeat (len) bytes.push_back($urandom_range(0, 1) ? a : b);
    end
    load_bytes(rss_pkg::CMD_PATTERN, bytes);
  endtask

  task automatic test_empty_buffers();
    run_search(1'b0);
    send_beat(CMD_NONE, 8'hFF, 1'b1);
    run_search(1'b1);
    send_beat(rss_pkg::CMD_TEXT, 8'h61, 1'b0);
    send_beat(rss_pkg::CMD_TEXT, 8'h62, 1'b0);
    run_search(1'b0);
    wait_drained();
  endtask

  task automatic test_zero_bytes();
    load_bytes(rss_pkg::CMD_TEXT, '{8'h00, 8'hFF, 8'h00, 8'h00});
    load_bytes(rss_pkg::CMD_PATTERN, '{8'h00, 8'h00});
    run_search(1'b0);
    load_bytes(rss_pkg::CMD_PATTERN, '{8'hFF});
    run_search(1'b0);
    load_bytes(rss_pkg::CMD_PATTERN, '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00});
    run_search(1'b0);
    wait_drained();
  endtask

  task automatic test_rightmost_choice();
    load_string(rss_pkg::CMD_TEXT, "abcabcab");
    load_string(rss_pkg::CMD_PATTERN, "ab");
    run_search(1'b0);
    load_string(rss_pkg::CMD_PATTERN, "abc");
    run_search(1'b0);
    load_string(rss_pkg::CMD_PATTERN, "abcabcab");
    run_search(1'b0);
    load_string(rss_pkg::CMD_PATTERN, "x");
    run_search(1'b0);
    send_beat(CMD_NONE, "c", 1'b0);
    load_string(rss_pkg::CMD_PATTERN, "abc");
    run_search(1'b1);
    send_beat(rss_pkg::CMD_TEXT, "c", 1'b0);
    run_search(1'b0);
    wait_drained();
  endtask

  task automatic test_full_buffers();
    logic [rss_pkg::BYTE_W-1:0] bytes[$];
    gap_max = 0;
    repeat (TEXT_DEPTH) bytes.push_back(rss_pkg::BYTE_W'($urandom));
    load_bytes(rss_pkg::CMD_TEXT, bytes);
    send_beat(rss_pkg::CMD_PATTERN, bytes[TEXT_DEPTH-1], 1'b1);
    run_search(1'b0);
    load_bytes(rss_pkg::CMD_PATTERN, bytes);
    run_search(1'b0);
    gap_max = 6;
    send_beat(rss_pkg::CMD_TEXT, rss_pkg::BYTE_W'($urandom), 1'b0);
    send_beat(rss_pkg::CMD_PATTERN, rss_pkg::BYTE_W'($urandom), 1'b0);
    run_search(1'b0);
    send_beat(rss_pkg::CMD_PATTERN, bytes[5], 1'b1);
    run_search(1'b1);
    wait_drained();
  endtask

  task automatic test_worst_case_scan();
    logic [rss_pkg::BYTE_W-1:0] bytes[$];
    logic [rss_pkg::BYTE_W-1:0] fill;
    fill = rss_pkg::BYTE_W'($urandom);
    repeat (TEXT_DEPTH) bytes.push_back(fill);
    load_bytes(rss_pkg::CMD_TEXT, bytes);
    bytes.delete();
    repeat (TEXT_DEPTH / 2 - 1) bytes.push_back(fill);
    bytes.push_back(fill ^ 8'h01);
    load_bytes(rss_pkg::CMD_PATTERN, bytes);
    run_search(1'b0);
    send_beat(rss_pkg::CMD_PATTERN, fill, 1'b1);
    repeat (TEXT_DEPTH / 2 - 1) send_beat(rss_pkg::CMD_PATTERN, fill, 1'b0);
    run_search(1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_beats, input int max_text);
    logic [rss_pkg::BYTE_W-1:0] alpha[2];
    logic [rss_pkg::BYTE_W-1:0] bytes[$];
    int start_count;
    int kind;
    int len;
    start_count = beats_sent;
    while (beats_sent - start_count < n_beats) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0)
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 39) == 0) wait_drained();
      foreach (alpha[i]) alpha[i] = rss_pkg::BYTE_W'($urandom);
      bytes.delete();
      if (kind < 55) begin
        len = $urandom_range(1, max_text);
        repeat (len) bytes.push_back($urandom_range(0, 1) ? alpha[0] : alpha[1]);
        load_bytes(rss_pkg::CMD_TEXT, bytes);
        send_pattern(alpha[0], alpha[1]);
        run_search(1'b0);
      end else if (kind < 70) begin
        send_pattern(alpha[0], alpha[1]);
        run_search(1'b0);
      end else if (kind < 82) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          if (text_len < GROW_LIMIT)
            send_beat(rss_pkg::CMD_TEXT, text_mem[$urandom_range(0, text_len - 1)], 1'b0);
        end
        run_search(1'b0);
      end else if (kind < 90) begin
        send_beat(CMD_NONE, rss_pkg::BYTE_W'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) run_search(1'b1);
      end else begin
        len = $urandom_range(1, max_text);
        repeat (len) bytes.push_back(rss_pkg::BYTE_W'($urandom));
        load_bytes(rss_pkg::CMD_TEXT, bytes);
        bytes.delete();
        len = $urandom_range(1, 3);
        repeat (len) bytes.push_back(rss_pkg::BYTE_W'($urandom));
        load_bytes(rss_pkg::CMD_PATTERN, bytes);
        run_search(1'b0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  rsp_ready <= 1'b1;
      STALL_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
      STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
      default:     rsp_ready <= (cycles % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    rss_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("result beat %h with none expected", rsp));
      end else begin
        want = expected_hits.pop_front();
        if (rsp.found !== want.found)
          report_mismatch($sformatf("found %b, want %b", rsp.found, want.found));
        if (rsp.match_index !== want.match_index)
          report_mismatch($sformatf("match_index %0d, want %0d",
                                    rsp.match_index, want.match_index));
        if (rsp.overflowed !== want.overflowed)
          report_mismatch($sformatf("overflowed %b, want %b", rsp.overflowed, want.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_hits.size());
      $display("** rightmost_substring_search_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_buffers();
    test_zero_bytes();
    test_rightmost_choice();
    test_random_traffic(320, 24);
    test_full_buffers();
    test_worst_case_scan();
    test_random_traffic(160, 24);
    req_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** rightmost_substring_search_unit: PASSED **");
    end else begin
      $display("** rightmost_substring_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
